// ===== rtl/pn3_pkg.sv =====
// ----------------------------------------------------------------------------
// pn3_pkg: shared types, constants and tables for the 3D gradient noise unit
// Holds the permutation table, the fixed-point widths of the datapath and
// the request and result payload types.
// ----------------------------------------------------------------------------
package pn3_pkg;

	localparam int COORD_W = 24;
	localparam int FR_W    = 16;                // working fraction width
	localparam int VAL_W   = 20;                // signed Q16 values, |v| < 4
	localparam int FADE_W  = 18;                // fade in Q16, 0..65536

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [FR_W-1:0]    frac_t;
	typedef logic signed [VAL_W-1:0] val_t;

	typedef struct packed {
		coord_t coord_x;
		coord_t coord_y;
		coord_t coord_z;
	} pn3_req_t;

	typedef struct packed {
		logic signed [15:0] noise_value;
		logic [7:0]         grey_level;
	} pn3_res_t;

	function automatic logic [7:0] perm_rom(input logic [7:0] idx);
		logic [7:0] t [256];
		t = '{
		151,160,137,91,90,15,131,13,201,95,96,53,194,233,7,225,140,36,103,30,69,142,
		8,99,37,240,21,10,23,190,6,148,247,120,234,75,0,26,197,62,94,252,219,203,117,
		35,11,32,57,177,33,88,237,149,56,87,174,20,125,136,171,168,68,175,74,165,71,
		134,139,48,27,166,77,146,158,231,83,111,229,122,60,211,133,230,220,105,92,41,
		55,46,245,40,244,102,143,54,65,25,63,161,1,216,80,73,209,76,132,187,208,89,
		18,169,200,196,135,130,116,188,159,86,164,100,109,198,173,186,3,64,52,217,226,
		250,124,123,5,202,38,147,118,126,255,82,85,212,207,206,59,227,47,16,58,17,182,
		189,28,42,223,183,170,213,119,248,152,2,44,154,163,70,221,153,101,155,167,43,
		172,9,129,22,39,253,19,98,108,110,79,113,224,232,178,185,112,104,218,246,97,
		228,251,34,242,193,238,210,144,12,191,179,162,241,81,51,145,235,249,14,239,
		107,49,192,214,31,181,199,106,157,184,84,204,176,115,121,50,45,127,4,150,254,
		138,236,205,93,222,114,67,29,24,72,243,141,128,195,78,66,215,61,156,180};
		return t[idx];
	endfunction

	// Gradient dot product: hash modulo 12 picks one of the twelve cube edges
	function automatic val_t grad_dot(input logic [7:0] h, input val_t dx,
		input val_t dy, input val_t dz);
		logic [16:0] pm;
		logic [7:0]  qt;
		logic [3:0]  g;
		// quotient by 12 through a reciprocal product, exact for any byte
		pm = h * 9'd342;
		qt = 8'(pm >> 12);
		g  = 4'(h - 8'(qt * 8'd12));
		case (g)
			4'd0:    return dx + dy;
			4'd1:    return -dx + dy;
			4'd2:    return dx - dy;
			4'd3:    return -dx - dy;
			4'd4:    return dx + dz;
			4'd5:    return -dx + dz;
			4'd6:    return dx - dz;
			4'd7:    return -dx - dz;
			4'd8:    return dy + dz;
			4'd9:    return -dy + dz;
			4'd10:   return dy - dz;
			default: return -dy - dz;
		endcase
	endfunction

endpackage

// ===== rtl/pn3_stream_if.sv =====
// ----------------------------------------------------------------------------
// pn3_stream_if: valid/ready channel
// Carries one payload per request; moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface pn3_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/perlin_noise_3d_unit.sv =====
// ----------------------------------------------------------------------------
// perlin_noise_3d_unit: classic 3D gradient noise, one point per request
// Pipelined evaluator of gradient noise with quintic fade and trilinear mix.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  (sink)  : coord_x/y/z, unsigned fixed point with FRAC_BITS fraction
//                    bits; the integer part wraps modulo CELL_PERIOD.
//   out_ch (source): noise_value (signed Q1.15) and grey_level (0..255).
// Throughput: one request per cycle, sustained while out_ch takes each result.
// Pipeline: the split and first hash, then four registered fade stages,
//   then three registered interpolation levels and two stages of output
//   scaling.
// Stall: the whole pipeline advances on one enable; while out_ch holds a
//   result that is not taken, in_ch.ready is low. Bubbles inside the
//   pipeline are not squeezed out, but nothing is lost or repeated.
// Reset: arst_n clears every valid bit; the permutation table is a constant
//   ROM and needs no fill.
// ----------------------------------------------------------------------------
module perlin_noise_3d_unit #(
	parameter int FRAC_BITS   = 16,
	parameter int CELL_PERIOD = 256
) (
	input  logic clk,
	input  logic arst_n,
	pn3_stream_if.sink   in_ch,
	pn3_stream_if.source out_ch
);
	import pn3_pkg::*;

	localparam int NST   = 10;
	localparam int CELLW = $clog2(CELL_PERIOD);
	localparam int IPW   = COORD_W - FRAC_BITS;
	localparam int IPX   = (IPW > 0) ? IPW : 1;
	localparam bit CELL_POW2 = ((1 << CELLW) == CELL_PERIOD);
	localparam int RSH   = IPX + CELLW;
	localparam int RMW   = IPX + 2;
	localparam longint RMUL = ((longint'(1) << RSH) + CELL_PERIOD - 1) / CELL_PERIOD;
	localparam val_t ONE = val_t'(65536);

	logic [NST-1:0] vld_q;
	logic           adv;
	pn3_req_t       req;

	assign req = in_ch.data;

	// Stage advances everywhere unless the output holds a result not taken
	assign adv         = !vld_q[NST-1] || out_ch.ready;
	assign in_ch.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NST-2:0], in_ch.valid};
		end
	end

	// ---- split coordinates ----
	function automatic frac_t get_frac(input coord_t c);
		logic [FRAC_BITS-1:0] f;
		f = c[FRAC_BITS-1:0];
		if (FRAC_BITS >= 16)
			return frac_t'(f >> (FRAC_BITS - 16));
		else
			return frac_t'({f, 16'd0} >> FRAC_BITS);
	endfunction

	function automatic logic [7:0] get_cell(input coord_t c);
		logic [IPX-1:0]   ip;
		logic [2*IPX+1:0] pr;
		logic [IPX-1:0]   qt;
		ip = IPX'(c >> FRAC_BITS);
		if (CELL_POW2)
			return 8'(ip & IPX'(CELL_PERIOD - 1));
		// remainder through a reciprocal product, exact over the integer range
		pr = ip * RMW'(RMUL);
		qt = IPX'(pr >> RSH);
		return 8'(ip - IPX'(qt * CELL_PERIOD));
	endfunction

	function automatic logic [7:0] next_cell(input logic [7:0] c);
		logic [8:0] n;
		n = {1'b0, c} + 9'd1;
		if (n >= 9'(CELL_PERIOD))
			n = '0;
		return n[7:0];
	endfunction

	// Stage 1: cells, fractions, first hash level
	logic [7:0] xi_s1, xj_s1, yi_s1, yj_s1, pz1_s1, pz2_s1;
	frac_t      fx_s1, fy_s1, fz_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			xi_s1  <= get_cell(req.coord_x);
			xj_s1  <= next_cell(get_cell(req.coord_x));
			yi_s1  <= get_cell(req.coord_y);
			yj_s1  <= next_cell(get_cell(req.coord_y));
			pz1_s1 <= perm_rom(get_cell(req.coord_z));
			pz2_s1 <= perm_rom(next_cell(get_cell(req.coord_z)));
			fx_s1  <= get_frac(req.coord_x);
			fy_s1  <= get_frac(req.coord_y);
			fz_s1  <= get_frac(req.coord_z);
		end
	end

	// Stage 2: second hash level; fade first multiplies t*a and t*t
	logic [7:0]        xi_s2, xj_s2, py_s2 [4];
	frac_t             fx_s2, fy_s2, fz_s2;
	logic signed [36:0] ta_s2 [3];
	logic [31:0]       tt_s2 [3];
	frac_t             f1 [3];

	assign f1[0] = fx_s1;
	assign f1[1] = fy_s1;
	assign f1[2] = fz_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			xi_s2    <= xi_s1;
			xj_s2    <= xj_s1;
			py_s2[0] <= perm_rom(yi_s1 + pz1_s1);
			py_s2[1] <= perm_rom(yi_s1 + pz2_s1);
			py_s2[2] <= perm_rom(yj_s1 + pz1_s1);
			py_s2[3] <= perm_rom(yj_s1 + pz2_s1);
			fx_s2    <= fx_s1;
			fy_s2    <= fy_s1;
			fz_s2    <= fz_s1;
			for (int k = 0; k < 3; k++) begin
				ta_s2[k] <= $signed({21'd0, f1[k]}) *
					($signed({3'd0, f1[k], 1'b0} + {2'd0, f1[k], 2'd0})
					- 37'sd983040);
				tt_s2[k] <= f1[k] * f1[k];
			end
		end
	end

	// Stage 3: corner hashes and dot products; fade b and d = c*t
	val_t               dot_s3 [8];
	frac_t              fx_s3, fy_s3, fz_s3;
	logic signed [20:0] b_s3 [3];
	logic [31:0]        d_s3 [3];
	frac_t              f2 [3];
	val_t               dxa, dxb, dya, dyb, dza, dzb;

	assign f2[0] = fx_s2;
	assign f2[1] = fy_s2;
	assign f2[2] = fz_s2;
	assign dxa = val_t'({1'b0, fx_s2});
	assign dya = val_t'({1'b0, fy_s2});
	assign dza = val_t'({1'b0, fz_s2});
	assign dxb = dxa - ONE;
	assign dyb = dya - ONE;
	assign dzb = dza - ONE;

	always_ff @(posedge clk) begin
		if (adv) begin
			dot_s3[0] <= grad_dot(perm_rom(xi_s2 + py_s2[0]), dxa, dya, dza);
			dot_s3[1] <= grad_dot(perm_rom(xi_s2 + py_s2[1]), dxa, dya, dzb);
			dot_s3[2] <= grad_dot(perm_rom(xi_s2 + py_s2[2]), dxa, dyb, dza);
			dot_s3[3] <= grad_dot(perm_rom(xi_s2 + py_s2[3]), dxa, dyb, dzb);
			dot_s3[4] <= grad_dot(perm_rom(xj_s2 + py_s2[0]), dxb, dya, dza);
			dot_s3[5] <= grad_dot(perm_rom(xj_s2 + py_s2[1]), dxb, dya, dzb);
			dot_s3[6] <= grad_dot(perm_rom(xj_s2 + py_s2[2]), dxb, dyb, dza);
			dot_s3[7] <= grad_dot(perm_rom(xj_s2 + py_s2[3]), dxb, dyb, dzb);
			fx_s3 <= fx_s2;
			fy_s3 <= fy_s2;
			fz_s3 <= fz_s2;
			for (int k = 0; k < 3; k++) begin
				b_s3[k] <= 21'(ta_s2[k] >>> 16) + 21'sd655360;
				d_s3[k] <= 32'((tt_s2[k] >> 16) * f2[k]);
			end
		end
	end

	// Stage 4: fade = (d >> 16) * b
	val_t               dot_s4 [8];
	logic signed [36:0] fp_s4 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			dot_s4 <= dot_s3;
			for (int k = 0; k < 3; k++)
				fp_s4[k] <= $signed({1'b0, d_s3[k][31:16]}) * b_s3[k];
		end
	end

	// Stage 5: floor the fades to Q16
	val_t                 dot_s5 [8];
	logic [FADE_W-1:0]    fd_s5 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			dot_s5 <= dot_s4;
			for (int k = 0; k < 3; k++)
				fd_s5[k] <= FADE_W'(fp_s4[k] >>> 16);
		end
	end

	function automatic val_t mix_f(input val_t a, input val_t b,
		input logic [FADE_W-1:0] f);
		logic signed [VAL_W:0]          df;
		logic signed [VAL_W+FADE_W+1:0] p;
		df = {b[VAL_W-1], b} - {a[VAL_W-1], a};
		p  = df * $signed({1'b0, f});
		return a + val_t'(p >>> 16);
	endfunction

	// Stages 6..8: interpolate along x, y, then z
	val_t              nx_s6 [4];
	logic [FADE_W-1:0] v_s6, w_s6, w_s7;
	val_t              ny_s7 [2];
	val_t              n_s8;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 4; k++)
				nx_s6[k] <= mix_f(dot_s5[k], dot_s5[k+4], fd_s5[0]);
			v_s6     <= fd_s5[1];
			w_s6     <= fd_s5[2];
			ny_s7[0] <= mix_f(nx_s6[0], nx_s6[2], v_s6);
			ny_s7[1] <= mix_f(nx_s6[1], nx_s6[3], v_s6);
			w_s7     <= w_s6;
			n_s8     <= mix_f(ny_s7[0], ny_s7[1], w_s7);
		end
	end

	// Stage 9: grey scale product; stage 10: saturate and present
	val_t        n_s9;
	logic [28:0] gp_s9;
	logic        gneg_s9;
	val_t        g8;
	pn3_res_t    res_s10;
	val_t        q;

	assign g8 = n_s8 + ONE;

	always_ff @(posedge clk) begin
		if (adv) begin
			n_s9    <= n_s8;
			gneg_s9 <= g8[VAL_W-1];
			gp_s9   <= 29'(g8[VAL_W-2:0]) * 29'd255;
		end
	end

	always_comb begin
		q = n_s9 >>> 1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (q > val_t'(32767))
				res_s10.noise_value <= 16'sh7fff;
			else if (q < -val_t'(32768))
				res_s10.noise_value <= -16'sh8000;
			else
				res_s10.noise_value <= q[15:0];
			if (gneg_s9)
				res_s10.grey_level <= 8'd0;
			else if (gp_s9[28:17] > 12'd255)
				res_s10.grey_level <= 8'd255;
			else
				res_s10.grey_level <= gp_s9[24:17];
		end
	end

	assign out_ch.valid = vld_q[NST-1];
	assign out_ch.data  = res_s10;

endmodule

// ===== sim/tb_perlin_noise_3d_unit.sv =====
// ----------------------------------------------------------------------------
// tb_perlin_noise_3d_unit: self-checking bench for the 3D gradient noise unit
// Drives directed and random points through the request channel under varied
// idling on both sides, predicts each noise and grey result in the bench (or
// takes the listed result for the lattice corners) and compares every returned
// result, in order, with the oldest prediction.
module tb_perlin_noise_3d_unit;
	import pn3_pkg::*;

	localparam int  LIMIT_CYCLES = 400000;
	localparam int  N_RANDOM     = 1130;
	localparam int  ONE          = 65536;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	pn3_stream_if #(.payload_t(pn3_req_t)) in_ch ();
	pn3_stream_if #(.payload_t(pn3_res_t)) out_ch ();

	perlin_noise_3d_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	typedef struct {
		pn3_req_t req;
		bit       known;
		pn3_res_t res;
	} stim_row_t;

	pn3_res_t  noise_q[$];
	int        errors = 0;
	int        results_seen = 0;
	int        cycle_cnt = 0;
	int        send_idle_pct = 35;
	int        recv_idle_pct = 75;
	stim_row_t rows[$];

	// Hash table and gradient signs, held locally
	byte unsigned perm_ref[256] = '{
		151,160,137,91,90,15,131,13,201,95,96,53,194,233,7,225,140,36,103,30,69,142,
		8,99,37,240,21,10,23,190,6,148,247,120,234,75,0,26,197,62,94,252,219,203,117,
		35,11,32,57,177,33,88,237,149,56,87,174,20,125,136,171,168,68,175,74,165,71,
		134,139,48,27,166,77,146,158,231,83,111,229,122,60,211,133,230,220,105,92,41,
		55,46,245,40,244,102,143,54,65,25,63,161,1,216,80,73,209,76,132,187,208,89,
		18,169,200,196,135,130,116,188,159,86,164,100,109,198,173,186,3,64,52,217,226,
		250,124,123,5,202,38,147,118,126,255,82,85,212,207,206,59,227,47,16,58,17,182,
		189,28,42,223,183,170,213,119,248,152,2,44,154,163,70,221,153,101,155,167,43,
		172,9,129,22,39,253,19,98,108,110,79,113,224,232,178,185,112,104,218,246,97,
		228,251,34,242,193,238,210,144,12,191,179,162,241,81,51,145,235,249,14,239,
		107,49,192,214,31,181,199,106,157,184,84,204,176,115,121,50,45,127,4,150,254,
		138,236,205,93,222,114,67,29,24,72,243,141,128,195,78,66,215,61,156,180};
	int edge_dir[12][3] = '{
		'{1,1,0}, '{-1,1,0}, '{1,-1,0}, '{-1,-1,0},
		'{1,0,1}, '{-1,0,1}, '{1,0,-1}, '{-1,0,-1},
		'{0,1,1}, '{0,-1,1}, '{0,1,-1}, '{0,-1,-1}};

	function automatic longint shr_floor(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint quintic(longint t);
		longint a, b, c, d;
		a = 6 * t - 15 * ONE;
		b = shr_floor(t * a, 16) + 10 * ONE;
		c = shr_floor(t * t, 16);
		d = shr_floor(c * t, 16);
		return shr_floor(d * b, 16);
	endfunction

	function automatic longint lerp16(longint a, longint b, longint f);
		return a + shr_floor((b - a) * f, 16);
	endfunction

	function automatic longint edge_dot(int h, longint dx, longint dy, longint dz);
		int g;
		g = h % 12;
		return edge_dir[g][0] * dx + edge_dir[g][1] * dy + edge_dir[g][2] * dz;
	endfunction

	function automatic pn3_res_t noise_at(pn3_req_t r);
		int       xi, yi, zi, xj, yj, zj, a1, a2, b1, b2, b3, b4;
		longint   fx, fy, fz, u, v, w, n, q, g;
		longint   c[8];
		pn3_res_t res;
		xi = r.coord_x[23:16]; yi = r.coord_y[23:16]; zi = r.coord_z[23:16];
		fx = r.coord_x[15:0];  fy = r.coord_y[15:0];  fz = r.coord_z[15:0];
		xj = (xi + 1) % 256; yj = (yi + 1) % 256; zj = (zi + 1) % 256;
		a1 = perm_ref[zi]; a2 = perm_ref[zj];
		b1 = perm_ref[(yi + a1) % 256]; b2 = perm_ref[(yi + a2) % 256];
		b3 = perm_ref[(yj + a1) % 256]; b4 = perm_ref[(yj + a2) % 256];
		c[0] = edge_dot(perm_ref[(xi + b1) % 256], fx, fy, fz);
		c[1] = edge_dot(perm_ref[(xi + b2) % 256], fx, fy, fz - ONE);
		c[2] = edge_dot(perm_ref[(xi + b3) % 256], fx, fy - ONE, fz);
		c[3] = edge_dot(perm_ref[(xi + b4) % 256], fx, fy - ONE, fz - ONE);
		c[4] = edge_dot(perm_ref[(xj + b1) % 256], fx - ONE, fy, fz);
		c[5] = edge_dot(perm_ref[(xj + b2) % 256], fx - ONE, fy, fz - ONE);
		c[6] = edge_dot(perm_ref[(xj + b3) % 256], fx - ONE, fy - ONE, fz);
		c[7] = edge_dot(perm_ref[(xj + b4) % 256], fx - ONE, fy - ONE, fz - ONE);
		u = quintic(fx); v = quintic(fy); w = quintic(fz);
		n = lerp16(lerp16(lerp16(c[0], c[4], u), lerp16(c[2], c[6], u), v),
			lerp16(lerp16(c[1], c[5], u), lerp16(c[3], c[7], u), v), w);
		q = shr_floor(n, 1);
		if (q > 32767) q = 32767;
		if (q < -32768) q = -32768;
		res.noise_value = 16'(q);
		g = n + ONE;
		if (g < 0) begin
			g = 0;
		end else begin
			g = (g * 255) >>> 17;
			if (g > 255) g = 255;
		end
		res.grey_level = 8'(g);
		return res;
	endfunction

	function automatic pn3_req_t pt(int x, int y, int z);
		pn3_req_t r;
		r.coord_x = 24'(x); r.coord_y = 24'(y); r.coord_z = 24'(z);
		return r;
	endfunction

	function automatic coord_t rand_coord();
		case ($urandom_range(0, 7))
			0:       return {8'($urandom), 16'h0000};
			1:       return {8'($urandom), 16'hFFFF};
			2:       return {8'hFF, 16'($urandom)};
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic add_row(pn3_req_t r, bit known, int nv, int gl);
		stim_row_t s;
		s.req = r; s.known = known;
		s.res.noise_value = 16'(nv); s.res.grey_level = 8'(gl);
		rows.push_back(s);
	endtask

	task automatic send_req(pn3_req_t r);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data  <= r;
		noise_q.push_back(noise_at(r));
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	task automatic drain();
		while (noise_q.size() != 0) @(posedge clk);
	endtask

	// Receiver: random back-pressure, compare on every accepted result
	always @(posedge clk) begin
		pn3_res_t exp_res;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				results_seen <= results_seen + 1;
				if (noise_q.size() == 0) begin
					$display("%0t: unexpected result %0d/%0d", $time,
						out_ch.data.noise_value, out_ch.data.grey_level);
					errors = errors + 1;
				end else begin
					exp_res = noise_q.pop_front();
					if (out_ch.data.noise_value !== exp_res.noise_value) begin
						$display("%0t: noise_value expected %0d got %0d", $time,
							exp_res.noise_value, out_ch.data.noise_value);
						errors = errors + 1;
					end
					if (out_ch.data.grey_level !== exp_res.grey_level) begin
						$display("%0t: grey_level expected %0d got %0d", $time,
							exp_res.grey_level, out_ch.data.grey_level);
						errors = errors + 1;
					end
				end
			end
			out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > LIMIT_CYCLES) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		pn3_req_t r;
		in_ch.valid  = 1'b0;
		in_ch.data   = '0;
		// Corners of the lattice give zero noise, mid grey
		add_row(pt(0, 0, 0), 1, 0, 127);
		add_row(pt(24'h010000, 24'h020000, 24'h030000), 1, 0, 127);
		add_row(pt(24'hFF0000, 24'hFF0000, 24'hFF0000), 1, 0, 127);
		// Extremes and period-edge cells: checked by prediction
		add_row(pt(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF), 0, 0, 0);
		add_row(pt(24'h00FFFF, 24'h00FFFF, 24'h00FFFF), 0, 0, 0);
		add_row(pt(24'hFF8000, 24'h008000, 24'hFF8000), 0, 0, 0);
		add_row(pt(24'h008000, 24'h008000, 24'h008000), 0, 0, 0);
		add_row(pt(24'hFFFFFF, 0, 0), 0, 0, 0);
		add_row(pt(0, 24'hFFFFFF, 0), 0, 0, 0);
		add_row(pt(0, 0, 24'hFFFFFF), 0, 0, 0);
		add_row(pt(24'hAAAAAA, 24'h555555, 24'hAAAAAA), 0, 0, 0);
		add_row(pt(24'h555555, 24'hAAAAAA, 24'h555555), 0, 0, 0);
		add_row(pt(24'h000001, 24'h000001, 24'h000001), 0, 0, 0);
		add_row(pt(24'hFE4000, 24'h7FC000, 24'h80FFFF), 0, 0, 0);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) begin
			send_req(rows[i].req);
			if (rows[i].known) begin
				noise_q[$] = rows[i].res;
			end
		end
		in_ch.valid <= 1'b0;
		// Hold off until everything in flight has returned
		drain();
		for (int k = 0; k < N_RANDOM; k++) begin
			if (k == N_RANDOM / 3) begin
				send_idle_pct = 75; recv_idle_pct = 35;
			end else if (k == 2 * N_RANDOM / 3) begin
				send_idle_pct = 0; recv_idle_pct = 0;
			end
			r.coord_x = rand_coord(); r.coord_y = rand_coord(); r.coord_z = rand_coord();
			send_req(r);
		end
		in_ch.valid <= 1'b0;
		drain();
		repeat (20) @(posedge clk);
		$display("Covered %0d directed and %0d random points, %0d results checked",
			rows.size(), N_RANDOM, results_seen);
		$display("under sender-heavy, receiver-heavy and no idling phases");
		if (errors == 0 && noise_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== perlin_noise_3d_unit.f =====
rtl/pn3_pkg.sv
rtl/pn3_stream_if.sv
rtl/perlin_noise_3d_unit.sv
sim/tb_perlin_noise_3d_unit.sv
